// ===== src/ptt_pkg.sv =====
// shared types and constants of the priority timer table
package ptt_pkg;

	localparam int NUM_SLOTS = 32;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int PRIORITY_LEVELS = 3;
	localparam int PRIO_W = 2;
	localparam int ITV_W = 22;
	localparam int TIME_W = 48;
	localparam int WORD_W = 32;
	localparam logic [ITV_W-1:0] MAX_ITV_RST = 22'd3600000;
	localparam logic [PRIO_W-1:0] ADD_PRIO = (PRIORITY_LEVELS > 1) ? 2'd1 : 2'd0;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_DROP = 4'd1,
		CMD_SUSPEND = 4'd2,
		CMD_RESUME = 4'd3,
		CMD_SET_PRIO = 4'd4,
		CMD_SET_ITV = 4'd5,
		CMD_TICK = 4'd6,
		CMD_NEXT = 4'd7,
		CMD_FIND = 4'd8,
		CMD_CLEAR = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_END
	} state_t;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_NEXT,
		MODE_FIND
	} scan_mode_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [WORD_W-1:0] age;
		logic [TIME_W-1:0] deadline;
	} cand_t;

endpackage

// ===== src/ptt_cmp.sv =====
// shared ordering comparator used by every scan step
module ptt_cmp
	import ptt_pkg::*;
(
	input scan_mode_t mode,
	input cand_t cand,
	input cand_t best,
	output logic better
);

	logic first;

	// priority level first, then insertion age
	always_comb begin
		first = (cand.prio < best.prio) ||
			((cand.prio == best.prio) && (cand.age < best.age));
	end

	always_comb begin
		unique case (mode)
			MODE_TICK: better = first;
			MODE_NEXT: better = (cand.deadline < best.deadline) ||
				((cand.deadline == best.deadline) && first);
			default: better = 1'b0;
		endcase
	end

endmodule

// ===== src/priority_timer_table.sv =====
// priority timer table: top level with command decode, slot store and scan sequencer
// simple commands: result in the cycle after the request, a new request the cycle after it
// find id and next query: one pass over the slots, then the chosen slot is reported
// tick: one pass per firing plus a final pass that finds nothing left to fire
// each pass walks the slots through the single shared comparator, reading one slot a cycle
// reset clears valid and suspended flags at once; results cannot be stalled
module priority_timer_table
	import ptt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [3:0] command,
	input logic [4:0] slot,
	input logic [TIME_W-1:0] now_ms,
	input logic [ITV_W-1:0] period_ms,
	input logic reload,
	input logic [1:0] level,
	input logic [WORD_W-1:0] query_id,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ITV_W-1:0] cfg_data,
	output logic result_valid,
	output logic [1:0] status,
	output logic [4:0] result_slot,
	output logic [WORD_W-1:0] result_id,
	output logic [TIME_W-1:0] result_deadline,
	output logic fired,
	output logic [WORD_W-1:0] run_count,
	output logic last
);

	state_t state_q, state_d;
	scan_mode_t mode_q, mode_d;

	logic [NUM_SLOTS-1:0] valid_q, susp_q, fired_q;
	logic reload_q [NUM_SLOTS];
	logic [PRIO_W-1:0] prio_q [NUM_SLOTS];
	logic [ITV_W-1:0] itv_q [NUM_SLOTS];
	logic [TIME_W-1:0] dl_q [NUM_SLOTS];
	logic [WORD_W-1:0] rc_q [NUM_SLOTS];
	logic [WORD_W-1:0] id_q [NUM_SLOTS];
	logic [WORD_W-1:0] order_q [NUM_SLOTS];

	logic [WORD_W-1:0] next_id_q, next_order_q;
	logic [ITV_W-1:0] max_itv_q;
	logic [TIME_W-1:0] now_q;
	logic [WORD_W-1:0] qid_q;
	logic [SLOT_W-1:0] idx_q, best_idx_q;
	logic found_q;
	cand_t best_q;

	logic pend_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [WORD_W-1:0] pend_id_q, pend_rc_q;
	logic [TIME_W-1:0] pend_dl_q;

	logic res_valid_q, res_fired_q, res_last_q;
	logic [1:0] res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [WORD_W-1:0] res_id_q, res_rc_q;
	logic [TIME_W-1:0] res_dl_q;

	logic accept;
	cmd_t cmd;
	logic [SLOT_W-1:0] rd_addr;
	logic rd_valid, rd_susp, rd_reload;
	logic [PRIO_W-1:0] rd_prio;
	logic [ITV_W-1:0] rd_itv;
	logic [TIME_W-1:0] rd_dl;
	logic [WORD_W-1:0] rd_rc, rd_id, rd_order;
	cand_t cand;
	logic better, elig, take;
	logic slot_oob, itv_bad, lvl_bad;
	logic imm_ok, imm_report, scan_cmd;
	status_t imm_status;
	logic [WORD_W-1:0] new_id;
	logic [TIME_W-1:0] add_dl;
	logic last_idx;
	logic [WORD_W-1:0] fire_rc;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign cmd = cmd_t'(command);

	// one read port shared by command slot, scan index and the chosen slot
	always_comb begin
		unique case (state_q)
			S_SCAN: rd_addr = idx_q;
			S_END: rd_addr = best_idx_q;
			default: rd_addr = slot;
		endcase
	end

	assign rd_valid = valid_q[rd_addr];
	assign rd_susp = susp_q[rd_addr];
	assign rd_reload = reload_q[rd_addr];
	assign rd_prio = prio_q[rd_addr];
	assign rd_itv = itv_q[rd_addr];
	assign rd_dl = dl_q[rd_addr];
	assign rd_rc = rc_q[rd_addr];
	assign rd_id = id_q[rd_addr];
	assign rd_order = order_q[rd_addr];

	assign cand.prio = rd_prio;
	assign cand.age = rd_order - next_order_q;
	assign cand.deadline = rd_dl;

	ptt_cmp u_cmp (
		.mode(mode_q),
		.cand(cand),
		.best(best_q),
		.better(better)
	);

	always_comb begin
		logic act;
		act = rd_valid && !rd_susp && ({1'b0, rd_prio} < 3'(PRIORITY_LEVELS));
		unique case (mode_q)
			MODE_TICK: elig = act && (rd_dl <= now_q) && !fired_q[idx_q];
			MODE_NEXT: elig = act && (rd_dl > now_q);
			default: elig = rd_valid && (rd_id == qid_q);
		endcase
	end

	assign take = elig && (!found_q || better);
	assign last_idx = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign fire_rc = rd_rc + 1'b1;

	// immediate command decode
	assign slot_oob = ({1'b0, slot} >= (SLOT_W + 1)'(NUM_SLOTS));
	assign itv_bad = (period_ms == '0) || (period_ms > max_itv_q);
	assign lvl_bad = ({1'b0, level} >= 3'(PRIORITY_LEVELS));
	assign new_id = next_id_q + 1'b1;
	assign add_dl = now_ms + TIME_W'(period_ms);

	always_comb begin
		imm_status = ST_OK;
		imm_report = 1'b0;
		scan_cmd = 1'b0;
		mode_d = MODE_FIND;
		unique case (cmd)
			CMD_ADD: begin
				if (itv_bad || slot_oob) imm_status = ST_INVALID;
				else imm_report = 1'b1;
			end
			CMD_DROP, CMD_SUSPEND, CMD_RESUME: begin
				if (slot_oob) imm_status = ST_INVALID;
				else if (!rd_valid) imm_status = ST_NOT_FOUND;
				else imm_report = 1'b1;
			end
			CMD_SET_PRIO: begin
				if (slot_oob || lvl_bad) imm_status = ST_INVALID;
				else if (!rd_valid) imm_status = ST_NOT_FOUND;
				else imm_report = 1'b1;
			end
			CMD_SET_ITV: begin
				if (itv_bad || slot_oob) imm_status = ST_INVALID;
				else if (!rd_valid) imm_status = ST_NOT_FOUND;
				else imm_report = 1'b1;
			end
			CMD_TICK: begin
				scan_cmd = 1'b1;
				mode_d = MODE_TICK;
			end
			CMD_NEXT: begin
				scan_cmd = 1'b1;
				mode_d = MODE_NEXT;
			end
			CMD_FIND: scan_cmd = 1'b1;
			CMD_CLEAR: imm_status = ST_OK;
			default: imm_status = ST_INVALID;
		endcase
	end
	assign imm_ok = accept && imm_report;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept && scan_cmd) state_d = S_SCAN;
			S_SCAN: if (last_idx) state_d = S_END;
			S_END: begin
				if (mode_q == MODE_TICK && found_q) state_d = S_SCAN;
				else state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_FIND;
			valid_q <= '0;
			susp_q <= '0;
			fired_q <= '0;
			next_id_q <= WORD_W'(1);
			next_order_q <= '0;
			max_itv_q <= MAX_ITV_RST;
			idx_q <= '0;
			found_q <= 1'b0;
			pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) max_itv_q <= cfg_data;
			if (state_q == S_IDLE) begin
				idx_q <= '0;
				found_q <= 1'b0;
				pend_q <= 1'b0;
				fired_q <= '0;
			end
			if (accept) begin
				mode_q <= mode_d;
				if (!scan_cmd) res_valid_q <= 1'b1;
				if (cmd == CMD_CLEAR) begin
					valid_q <= '0;
					susp_q <= '0;
				end
				if (imm_ok) begin
					unique case (cmd)
						CMD_ADD: begin
							next_id_q <= new_id;
							next_order_q <= next_order_q + 1'b1;
							valid_q[slot] <= 1'b1;
							susp_q[slot] <= 1'b0;
						end
						CMD_DROP: begin
							valid_q[slot] <= 1'b0;
							susp_q[slot] <= 1'b0;
						end
						CMD_SUSPEND: susp_q[slot] <= 1'b1;
						CMD_RESUME: begin
							susp_q[slot] <= 1'b0;
							next_order_q <= next_order_q + 1'b1;
						end
						CMD_SET_PRIO: next_order_q <= next_order_q + 1'b1;
						default: ;
					endcase
				end
			end
			if (state_q == S_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (take) found_q <= 1'b1;
			end
			if (state_q == S_END) begin
				idx_q <= '0;
				found_q <= 1'b0;
				if (mode_q == MODE_TICK && found_q) begin
					pend_q <= 1'b1;
					fired_q[best_idx_q] <= 1'b1;
					if (!rd_reload) valid_q[best_idx_q] <= 1'b0;
					if (pend_q) res_valid_q <= 1'b1;
				end else begin
					res_valid_q <= 1'b1;
				end
			end
		end
	end

	// slot payload and result registers
	always_ff @(posedge clk) begin
		if (imm_ok) begin
			unique case (cmd)
				CMD_ADD: begin
					reload_q[slot] <= reload;
					prio_q[slot] <= ADD_PRIO;
					itv_q[slot] <= period_ms;
					dl_q[slot] <= add_dl;
					rc_q[slot] <= '0;
					id_q[slot] <= new_id;
					order_q[slot] <= next_order_q;
				end
				CMD_RESUME: order_q[slot] <= next_order_q;
				CMD_SET_PRIO: begin
					prio_q[slot] <= level;
					order_q[slot] <= next_order_q;
				end
				CMD_SET_ITV: itv_q[slot] <= period_ms;
				default: ;
			endcase
		end
		if (accept) begin
			now_q <= now_ms;
			qid_q <= query_id;
			res_status_q <= imm_status;
			res_fired_q <= 1'b0;
			res_rc_q <= '0;
			res_last_q <= 1'b1;
			if (imm_report) begin
				res_slot_q <= slot;
				res_id_q <= (cmd == CMD_ADD) ? new_id : rd_id;
				res_dl_q <= (cmd == CMD_ADD) ? add_dl : rd_dl;
			end else begin
				res_slot_q <= '0;
				res_id_q <= '0;
				res_dl_q <= '0;
			end
		end
		if (state_q == S_SCAN && take) begin
			best_idx_q <= idx_q;
			best_q <= cand;
		end
		if (state_q == S_END) begin
			if (mode_q == MODE_TICK && found_q) begin
				rc_q[best_idx_q] <= fire_rc;
				if (rd_reload) dl_q[best_idx_q] <= now_q + TIME_W'(rd_itv);
				pend_slot_q <= best_idx_q;
				pend_id_q <= rd_id;
				pend_dl_q <= rd_dl;
				pend_rc_q <= fire_rc;
				// a previously held firing, if any, goes out now, more may follow
				res_status_q <= ST_OK;
				res_slot_q <= pend_slot_q;
				res_id_q <= pend_id_q;
				res_dl_q <= pend_dl_q;
				res_fired_q <= 1'b1;
				res_rc_q <= pend_rc_q;
				res_last_q <= 1'b0;
			end else if (mode_q == MODE_TICK) begin
				res_status_q <= ST_OK;
				res_slot_q <= pend_q ? pend_slot_q : '0;
				res_id_q <= pend_q ? pend_id_q : '0;
				res_dl_q <= pend_q ? pend_dl_q : '0;
				res_fired_q <= pend_q;
				res_rc_q <= pend_q ? pend_rc_q : '0;
				res_last_q <= 1'b1;
			end else begin
				res_status_q <= found_q ? ST_OK : ST_NOT_FOUND;
				res_slot_q <= found_q ? best_idx_q : '0;
				res_id_q <= found_q ? rd_id : '0;
				res_dl_q <= found_q ? rd_dl : '0;
				res_fired_q <= 1'b0;
				res_rc_q <= '0;
				res_last_q <= 1'b1;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status = res_status_q;
	assign result_slot = res_slot_q;
	assign result_id = res_id_q;
	assign result_deadline = res_dl_q;
	assign fired = res_fired_q;
	assign run_count = res_rc_q;
	assign last = res_last_q;

endmodule

// ===== src/ptt_check.sv =====
// port-level checks of the priority timer table
module ptt_check
	import ptt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic [1:0] status,
	input logic fired,
	input logic [WORD_W-1:0] run_count,
	input logic last
);

	// a result that is not the final one leaves the request still running
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy) else $error("non-final result while idle");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fired |-> status == ST_OK) else $error("firing with error status");

	a_rc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !fired |-> run_count == '0) else $error("run count without firing");

	// an accepted request either answers next cycle or keeps the block busy
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || result_valid) else $error("request dropped");

endmodule

bind priority_timer_table ptt_check u_ptt_check (.*);
